// ===== rtl/core/rsa_pkg.sv =====
// Shared types and constants for the reference-counted slot allocator.
// No dependencies; rsa_first_free, the top level and the checker import this package.
package rsa_pkg;

  localparam int SLOT_COUNT_DEF  = 32;
  localparam int COUNT_WIDTH_DEF = 16;

  localparam int ACTION_W    = 2;
  localparam int SLOT_IN_W   = 5;
  localparam int STATUS_W    = 2;
  localparam int SERIAL_W    = 32;
  localparam int COUNT_OUT_W = 16;
  localparam int COUNT_EXT_W = 32;

  typedef enum logic [ACTION_W-1:0] {
    ACT_ALLOC = 2'd0,
    ACT_GET   = 2'd1,
    ACT_PUT   = 2'd2,
    ACT_FREE  = 2'd3
  } action_t;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_FULL     = 2'd1,
    STATUS_PUT_ZERO = 2'd2
  } status_t;

  // Result of the lowest-free-slot search.
  typedef struct packed {
    logic                 found;
    logic [SLOT_IN_W-1:0] index;
  } grant_t;

endpackage

// ===== rtl/core/rsa_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependencies.
module rsa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/rsa_first_free.sv =====
// Priority encoder that finds the lowest clear bit of the use bitmap.
// Depends on rsa_pkg for the grant_t result struct.
module rsa_first_free #(
  parameter int SLOT_COUNT = rsa_pkg::SLOT_COUNT_DEF
) (
  input  logic [SLOT_COUNT-1:0] used_map,
  output rsa_pkg::grant_t       grant
);
  import rsa_pkg::*;

  always_comb begin
    grant = '0;
    // Scan downward so the lowest free slot wins.
    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
      if (!used_map[i]) begin
        grant.found = 1'b1;
        grant.index = SLOT_IN_W'(i);
      end
    end
  end

endmodule

// ===== rtl/core/refcounted_slot_allocator.sv =====
// Top level of the reference-counted slot allocator.
// Depends on rsa_pkg, rsa_ram (count store) and rsa_first_free (slot search).

// A request is taken when start is high and busy is low; a read step fetches
// the slot's reference count from the count memory, and then an update step
// computes the update, writes it back and registers the
// result. done pulses for one cycle with the result in the cycle after busy
// drops, and the receiver cannot stall it, so it must take the result then.
// A new request may be issued in that same cycle; none is taken while busy
// is high. The pool is empty right after reset with no clearing pass: one
// valid bit per slot makes an unwritten count read as zero.
module refcounted_slot_allocator #(
  parameter int SLOT_COUNT  = rsa_pkg::SLOT_COUNT_DEF,
  parameter int COUNT_WIDTH = rsa_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [rsa_pkg::ACTION_W-1:0]    action,
  input  logic [rsa_pkg::SLOT_IN_W-1:0]   slot,
  output logic                            busy,
  output logic                            done,
  output logic [rsa_pkg::STATUS_W-1:0]    status,
  output logic [rsa_pkg::SLOT_IN_W-1:0]   slot_out,
  output logic [rsa_pkg::SERIAL_W-1:0]    serial,
  output logic [rsa_pkg::COUNT_OUT_W-1:0] count_after,
  output logic                            released
);
  import rsa_pkg::*;

  localparam int SLOT_W = $clog2(SLOT_COUNT);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
  localparam logic [SLOT_IN_W:0] SLOT_LIMIT = (SLOT_IN_W + 1)'(SLOT_COUNT);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t state, state_next;

  logic [SLOT_COUNT-1:0] used_map, used_map_next;
  logic [SLOT_COUNT-1:0] cnt_valid, cnt_valid_next;
  logic [SERIAL_W-1:0]   next_serial, next_serial_next;

  // Request captured at accept
  action_t              act_q;
  logic [SLOT_IN_W-1:0] slot_q;
  logic                 in_range_q;
  logic                 cnt_valid_q;

  logic                 accept;
  logic                 in_range;
  logic [SLOT_W-1:0]    slot_idx;
  logic [SLOT_W-1:0]    slot_q_idx;

  logic                   ram_we;
  logic [SLOT_W-1:0]      ram_waddr;
  logic [COUNT_WIDTH-1:0] ram_wdata;
  logic [COUNT_WIDTH-1:0] ram_rdata;

  grant_t                 grant;
  logic [COUNT_WIDTH-1:0] cur;
  logic [COUNT_WIDTH-1:0] cnt_new;

  status_t                res_status;
  logic [SLOT_IN_W-1:0]   res_slot;
  logic [SERIAL_W-1:0]    res_serial;
  logic [COUNT_WIDTH-1:0] res_count;
  logic [COUNT_EXT_W-1:0] res_count_ext;
  logic                   res_released;

  assign busy       = (state != S_IDLE);
  assign accept     = start && (state == S_IDLE);
  assign in_range   = ({1'b0, slot} < SLOT_LIMIT);
  assign slot_idx   = slot[SLOT_W-1:0];
  assign slot_q_idx = slot_q[SLOT_W-1:0];

  rsa_ram #(
    .WIDTH (COUNT_WIDTH),
    .DEPTH (SLOT_COUNT)
  ) u_count_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (slot_idx),
    .rdata (ram_rdata)
  );

  rsa_first_free #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_first_free (
    .used_map (used_map),
    .grant    (grant)
  );

  // Counts never written since reset read as zero
  assign cur = cnt_valid_q ? ram_rdata : '0;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    used_map_next    = used_map;
    cnt_valid_next   = cnt_valid;
    next_serial_next = next_serial;
    ram_we           = 1'b0;
    ram_waddr        = slot_q_idx;
    ram_wdata        = '0;
    cnt_new          = '0;
    res_status       = STATUS_OK;
    res_slot         = slot_q;
    res_serial       = '0;
    res_count        = '0;
    res_released     = 1'b0;
    if (state == S_EXEC) begin
      case (act_q)
        ACT_ALLOC: begin
          res_slot = '0;
          if (!grant.found) begin
            res_status = STATUS_FULL;
          end else begin
            ram_we                                = 1'b1;
            ram_waddr                             = grant.index[SLOT_W-1:0];
            ram_wdata                             = COUNT_WIDTH'(1);
            used_map_next[grant.index[SLOT_W-1:0]]  = 1'b1;
            cnt_valid_next[grant.index[SLOT_W-1:0]] = 1'b1;
            next_serial_next                      = next_serial + SERIAL_W'(1);
            res_slot                              = grant.index;
            res_serial                            = next_serial;
            res_count                             = COUNT_WIDTH'(1);
          end
        end
        ACT_GET: begin
          if (in_range_q) begin
            // Saturate at the largest count
            cnt_new                    = (cur == COUNT_MAX) ? cur : cur + COUNT_WIDTH'(1);
            ram_we                     = 1'b1;
            ram_wdata                  = cnt_new;
            cnt_valid_next[slot_q_idx] = 1'b1;
            res_count                  = cnt_new;
          end
        end
        ACT_PUT: begin
          if (in_range_q) begin
            if (cur == '0) begin
              res_status = STATUS_PUT_ZERO;
            end else begin
              cnt_new                    = cur - COUNT_WIDTH'(1);
              ram_we                     = 1'b1;
              ram_wdata                  = cnt_new;
              cnt_valid_next[slot_q_idx] = 1'b1;
              if (cnt_new == '0) begin
                used_map_next[slot_q_idx] = 1'b0;
                res_released              = 1'b1;
              end else begin
                res_count = cnt_new;
              end
            end
          end
        end
        ACT_FREE: begin
          if (in_range_q) begin
            ram_we                     = 1'b1;
            ram_wdata                  = '0;
            cnt_valid_next[slot_q_idx] = 1'b1;
            used_map_next[slot_q_idx]  = 1'b0;
            res_released               = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign res_count_ext = COUNT_EXT_W'(res_count);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      used_map    <= '0;
      cnt_valid   <= '0;
      next_serial <= SERIAL_W'(1);
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      used_map    <= used_map_next;
      cnt_valid   <= cnt_valid_next;
      next_serial <= next_serial_next;
      done        <= (state == S_EXEC);
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      act_q       <= action_t'(action);
      slot_q      <= slot;
      in_range_q  <= in_range;
      cnt_valid_q <= in_range ? cnt_valid[slot_idx] : 1'b0;
    end
    if (state == S_EXEC) begin
      status      <= res_status;
      slot_out    <= res_slot;
      serial      <= res_serial;
      count_after <= res_count_ext[COUNT_OUT_W-1:0];
      released    <= res_released;
    end
  end

endmodule

// ===== rtl/core/rsa_checker.sv =====
// Port-level assertions for the reference-counted slot allocator, bound to
// the top level. Depends on rsa_pkg for the status codes.
module rsa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            start,
  input logic [rsa_pkg::ACTION_W-1:0]    action,
  input logic [rsa_pkg::SLOT_IN_W-1:0]   slot,
  input logic                            busy,
  input logic                            done,
  input logic [rsa_pkg::STATUS_W-1:0]    status,
  input logic [rsa_pkg::SLOT_IN_W-1:0]   slot_out,
  input logic [rsa_pkg::SERIAL_W-1:0]    serial,
  input logic [rsa_pkg::COUNT_OUT_W-1:0] count_after,
  input logic                            released
);
  import rsa_pkg::*;

  // Every accepted request raises busy, then completes with done high and busy low
  a_accept_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy ##1 (done && !busy))
    else $error("request did not complete on schedule");

  // A result only follows a busy cycle
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(busy))
    else $error("result without a request in flight");

  // A full pool grants nothing
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_FULL)) |->
      (slot_out == '0) && (serial == '0) && (count_after == '0) && !released)
    else $error("pool-full result carries data");

  // A release leaves the slot with no references
  a_release_zero: assert property (@(posedge clk) disable iff (rst)
    (done && released) |-> (count_after == '0) && (status == STATUS_OK))
    else $error("released slot reports a nonzero count");

  // An ignored put carries neither a serial nor a count
  a_serial_put: assert property (@(posedge clk) disable iff (rst)
    (done && (status == STATUS_PUT_ZERO)) |-> (serial == '0) && (count_after == '0))
    else $error("ignored put reports a serial or count");

endmodule

bind refcounted_slot_allocator rsa_checker u_rsa_checker (.*);
